>>> sv/ata_pkg.sv
// shared types, codes and constants for the ata pio task-file device
package ata_pkg;

  localparam int unsigned MaxSectors = 256;
  localparam int unsigned WordsPerSector = 256;
  localparam int unsigned BufDepth = 65536;
  localparam int unsigned BufAw = 16;
  localparam int unsigned PosW = 17;

  // request types
  localparam logic [1:0] REQ_RD = 2'd0;
  localparam logic [1:0] REQ_WR = 2'd1;
  localparam logic [1:0] REQ_MEDIA = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_HOST = 2'd0;
  localparam logic [1:0] KIND_MREQ = 2'd1;
  localparam logic [1:0] KIND_MWR = 2'd2;

  // register addresses
  localparam logic [3:0] REG_DATA = 4'd0;
  localparam logic [3:0] REG_ERR = 4'd1;
  localparam logic [3:0] REG_COUNT = 4'd2;
  localparam logic [3:0] REG_LBA0 = 4'd3;
  localparam logic [3:0] REG_LBA1 = 4'd4;
  localparam logic [3:0] REG_LBA2 = 4'd5;
  localparam logic [3:0] REG_DRIVE = 4'd6;
  localparam logic [3:0] REG_CMD = 4'd7;
  localparam logic [3:0] REG_ALT = 4'd8;

  localparam logic [7:0] CMD_READ = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] DRIVE_RESET = 8'hE0;
  localparam logic [7:0] STATUS_RESET = 8'h50;
  localparam int unsigned DrvLbaBit = 6;
  localparam int unsigned StDrqBit = 3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] reg_addr;
    logic [15:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [15:0] data_out;
    logic [27:0] media_lba;
    logic [16:0] media_count;
    logic [15:0] media_index;
  } out_item_t;

  // classified request handed from front to back
  typedef struct packed {
    logic host_rd;
    logic host_wr;
    logic media;
    logic [3:0] reg_addr;
    logic [15:0] data_in;
  } op_t;

  // words for a sector count, zero meaning the maximum
  function automatic logic [PosW-1:0] words_wanted(input logic [7:0] cnt);
    logic [PosW-1:0] n;
    n = (cnt == 8'd0) ? PosW'(256) : PosW'(cnt);
    if (n > PosW'(MaxSectors)) n = PosW'(MaxSectors);
    return PosW'(n * PosW'(WordsPerSector));
  endfunction

endpackage

>>> sv/ata_pio_task_file_device.sv
// top level of the ata pio task-file device with 28-bit lba
// results: registered, valid the cycle after the back end takes the request
// throughput: one request per cycle unless the output stalls; a data-register read
// that hits the buffer holds the back end for the registered buffer ram read
// reset: synchronous, clears registers to drive 0xE0 status 0x50 and empties queues
// the sector buffer ram has no reset and is only read where already filled
module ata_pio_task_file_device (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ata_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ata_pkg::out_item_t out_data
);

  logic op_valid, op_take;
  ata_pkg::op_t op;

  ata_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .op_valid(op_valid), .op_take(op_take), .op(op)
  );

  ata_back u_back (
    .clk(clk), .rst(rst),
    .op_valid(op_valid), .op_take(op_take), .op(op),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

>>> sv/ata_ram.sv
// generic single-port write, single read ram with registered read data
module ata_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

>>> sv/ata_front.sv
// front end: accepts requests, classifies them and queues them for the back end
module ata_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ata_pkg::in_item_t in_data,
  output logic           op_valid,
  input  logic           op_take,
  output ata_pkg::op_t   op
);

  ata_pkg::op_t q [2];
  logic [1:0] count;
  logic rd_ptr, wr_ptr;
  logic push, pop;
  ata_pkg::op_t cls;

  // classify the incoming beat
  always_comb begin
    cls.host_rd = (in_data.req_type == ata_pkg::REQ_RD);
    cls.host_wr = (in_data.req_type == ata_pkg::REQ_WR);
    cls.media = (in_data.req_type == ata_pkg::REQ_MEDIA);
    cls.reg_addr = in_data.reg_addr;
    cls.data_in = in_data.data_in;
  end

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign op_valid = (count != 2'd0);
  assign pop = op_valid && op_take;
  assign op = q[rd_ptr];

  // two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");
`endif

endmodule

>>> sv/ata_back.sv
// back end: task-file registers, transfer control and sector buffer
module ata_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_take,
  input  ata_pkg::op_t      op,
  output logic              out_valid,
  input  logic              out_stall,
  output ata_pkg::out_item_t out_data
);

  logic [7:0] drive_reg, status_reg, current_cmd, sector_count;
  logic [23:0] lba_low24;
  logic xfer_active;
  logic [ata_pkg::PosW-1:0] xfer_pos, xfer_size, fill_pos;

  // data read waiting on the buffer read
  logic rd_wait;
  logic [15:0] rdata;

  logic [27:0] cur_lba;
  logic go;
  logic buf_we, buf_re;
  logic res_valid;
  ata_pkg::out_item_t res;
  ata_pkg::out_item_t out_reg;
  logic is_data_rd, rd_hit;
  logic [ata_pkg::PosW-1:0] pos_inc, fill_inc, words;

  assign cur_lba = drive_reg[ata_pkg::DrvLbaBit] ? {drive_reg[3:0], lba_low24} : 28'd0;
  assign pos_inc = xfer_pos + 1'b1;
  assign fill_inc = fill_pos + 1'b1;
  assign words = ata_pkg::words_wanted(sector_count);

  // one op per cycle when the output register is free and no buffer read pends
  assign go = op_valid && !rd_wait && (!out_valid || !out_stall);
  assign op_take = go;

  assign is_data_rd = op.host_rd && (op.reg_addr == ata_pkg::REG_DATA);
  assign rd_hit = is_data_rd && (xfer_pos < xfer_size) && xfer_active
                  && (current_cmd == ata_pkg::CMD_READ) && (xfer_pos < fill_pos);
  assign buf_re = go && rd_hit;
  assign buf_we = go && op.media && (current_cmd == ata_pkg::CMD_READ)
                  && xfer_active && (fill_pos < xfer_size);

  ata_ram #(.Width(16), .Depth(ata_pkg::BufDepth)) u_buf (
    .clk(clk),
    .we(buf_we),
    .waddr(fill_pos[ata_pkg::BufAw-1:0]),
    .wdata(op.data_in),
    .re(buf_re),
    .raddr(xfer_pos[ata_pkg::BufAw-1:0]),
    .rdata(rdata)
  );

  // result of the op in hand
  always_comb begin
    res_valid = 1'b0;
    res = '0;
    if (op.host_rd) begin
      res_valid = 1'b1;
      res.out_kind = ata_pkg::KIND_HOST;
      case (op.reg_addr)
        ata_pkg::REG_DATA: res.data_out = 16'd0;
        ata_pkg::REG_ERR: res.data_out = 16'd0;
        ata_pkg::REG_COUNT: res.data_out = {8'd0, sector_count};
        ata_pkg::REG_LBA0: res.data_out = {8'd0, lba_low24[7:0]};
        ata_pkg::REG_LBA1: res.data_out = {8'd0, lba_low24[15:8]};
        ata_pkg::REG_LBA2: res.data_out = {8'd0, lba_low24[23:16]};
        ata_pkg::REG_DRIVE: res.data_out = {8'd0, drive_reg};
        ata_pkg::REG_CMD, ata_pkg::REG_ALT: res.data_out = {8'd0, status_reg};
        default: res.data_out = 16'hFFFF;
      endcase
    end else if (op.host_wr && op.reg_addr == ata_pkg::REG_DATA) begin
      if (current_cmd == ata_pkg::CMD_WRITE && xfer_active && xfer_pos < xfer_size) begin
        res_valid = 1'b1;
        res.out_kind = ata_pkg::KIND_MWR;
        res.data_out = op.data_in;
        res.media_lba = cur_lba;
        res.media_count = xfer_size;
        res.media_index = xfer_pos[15:0];
      end
    end else if (op.host_wr && op.reg_addr == ata_pkg::REG_CMD
                 && op.data_in[7:0] == ata_pkg::CMD_READ) begin
      res_valid = 1'b1;
      res.out_kind = ata_pkg::KIND_MREQ;
      res.media_lba = cur_lba;
      res.media_count = words;
    end
  end

  // output register, data word patched in after the buffer read
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_wait <= 1'b0;
    end else begin
      rd_wait <= buf_re;
      if (go) out_valid <= res_valid;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) out_reg <= res;
    else if (rd_wait) out_reg.data_out <= rdata;
  end

  // the buffer word goes straight out in the cycle after its read
  always_comb begin
    out_data = out_reg;
    if (rd_wait) out_data.data_out = rdata;
  end

  // register file and transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_reg <= ata_pkg::DRIVE_RESET;
      status_reg <= ata_pkg::STATUS_RESET;
      current_cmd <= 8'd0;
      sector_count <= 8'd0;
      lba_low24 <= 24'd0;
      xfer_active <= 1'b0;
      xfer_pos <= '0;
      xfer_size <= '0;
      fill_pos <= '0;
    end else if (go) begin
      if (is_data_rd) begin
        if (xfer_pos >= xfer_size || !xfer_active) begin
          xfer_active <= 1'b0;
          current_cmd <= 8'd0;
          status_reg[ata_pkg::StDrqBit] <= 1'b0;
        end else if (rd_hit) begin
          xfer_pos <= pos_inc;
        end
      end else if (buf_we) begin
        fill_pos <= fill_inc;
        if (fill_inc >= xfer_size) status_reg[ata_pkg::StDrqBit] <= 1'b1;
      end else if (op.host_wr) begin
        case (op.reg_addr)
          ata_pkg::REG_DATA: begin
            if (res_valid) begin
              xfer_pos <= pos_inc;
              if (pos_inc >= xfer_size) begin
                xfer_active <= 1'b0;
                status_reg[ata_pkg::StDrqBit] <= 1'b0;
              end
            end
          end
          ata_pkg::REG_COUNT: sector_count <= op.data_in[7:0];
          ata_pkg::REG_LBA0: lba_low24[7:0] <= op.data_in[7:0];
          ata_pkg::REG_LBA1: lba_low24[15:8] <= op.data_in[7:0];
          ata_pkg::REG_LBA2: lba_low24[23:16] <= op.data_in[7:0];
          ata_pkg::REG_DRIVE: drive_reg <= op.data_in[7:0];
          ata_pkg::REG_CMD: begin
            current_cmd <= op.data_in[7:0];
            xfer_active <= 1'b0;
            status_reg[ata_pkg::StDrqBit] <= 1'b0;
            if (op.data_in[7:0] == ata_pkg::CMD_READ
                || op.data_in[7:0] == ata_pkg::CMD_WRITE) begin
              xfer_pos <= '0;
              fill_pos <= '0;
              xfer_size <= words;
              xfer_active <= 1'b1;
              if (op.data_in[7:0] == ata_pkg::CMD_WRITE)
                status_reg[ata_pkg::StDrqBit] <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_wait_one: assert property (@(posedge clk) disable iff (rst)
    rd_wait |-> !buf_re) else $error("back-to-back buffer reads");
  a_wait_out: assert property (@(posedge clk) disable iff (rst)
    rd_wait |-> out_valid) else $error("buffer read without a result");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    buf_we |-> fill_pos < xfer_size) else $error("fill past transfer");
  a_pos_fill: assert property (@(posedge clk) disable iff (rst)
    buf_re |-> xfer_pos < fill_pos) else $error("read of unfilled word");
`endif

endmodule
